@@ hw/rtl/cpu8_pkg.sv @@
// shared types and constants of the code page to utf-8 encoder
package cpu8_pkg;

    // input operation codes
    localparam logic OP_CONVERT = 1'b0;
    localparam logic OP_LOAD    = 1'b1;

    // code point and table geometry
    localparam int CP_W         = 21;
    localparam int ENTRY_W      = 32;
    localparam int TABLE_DEPTH  = 128;
    localparam int TABLE_AW     = $clog2(TABLE_DEPTH);

    localparam logic [7:0]         HIGH_BASE    = 8'h80;
    localparam logic [ENTRY_W-1:0] MAX_CP       = 32'h0010_FFFF;
    localparam logic [CP_W-1:0]    ERR_CP_RESET = 21'd46;

    // queue between the front and the back
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // classified item waiting for serialization
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            sub;
    } t_item;

endpackage

@@ hw/rtl/cpu8_ram.sv @@
// generic single write port ram with registered read
module cpu8_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/cpu8_front.sv @@
// front: accepts items, writes and reads the code table, classifies bytes
module cpu8_front import cpu8_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_op,
    input  logic [7:0]         i_data_byte,
    input  logic [TABLE_AW-1:0] i_entry_index,
    input  logic [ENTRY_W-1:0] i_entry_code_point,
    input  logic [CP_W-1:0]    i_err_cp,
    output t_item              o_item,
    output logic               o_push_valid,
    input  logic               i_push_ready
);

    logic               accept;
    logic               is_conv;
    logic               is_high;
    logic               bad_cp;
    logic [ENTRY_W-1:0] rdata;

    logic       r_s1_valid;
    logic       n_s1_valid;
    logic       r_s1_high;
    logic [7:0] r_s1_byte;

    // input transaction handshake
    assign o_stall = r_s1_valid && !i_push_ready;
    assign accept  = i_valid && !o_stall;
    assign is_conv = (i_op == OP_CONVERT);
    assign is_high = (i_data_byte >= HIGH_BASE);

    // code table
    cpu8_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (accept && (i_op == OP_LOAD)),
        .i_waddr (i_entry_index),
        .i_wdata (i_entry_code_point),
        .i_re    (accept && is_conv && is_high),
        .i_raddr (i_data_byte[TABLE_AW-1:0]),
        .o_rdata (rdata)
    );

    // stage one holds a byte that produces output
    always_comb begin
        if (accept) begin
            n_s1_valid = is_conv && (i_data_byte != 8'h00);
        end else if (i_push_ready) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_high <= is_high;
            r_s1_byte <= i_data_byte;
        end
    end

    // classify: ascii, table code point, or error replacement
    assign bad_cp = r_s1_high && (rdata > MAX_CP);

    always_comb begin
        if (!r_s1_high) begin
            o_item.cp  = {{(CP_W-8){1'b0}}, r_s1_byte};
            o_item.sub = 1'b0;
        end else if (bad_cp) begin
            o_item.cp  = i_err_cp;
            o_item.sub = 1'b1;
        end else begin
            o_item.cp  = rdata[CP_W-1:0];
            o_item.sub = 1'b0;
        end
    end

    assign o_push_valid = r_s1_valid;

endmodule

@@ hw/rtl/cpu8_fifo.sv @@
// short queue between the front and the back
module cpu8_fifo import cpu8_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_item i_item,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    output t_item o_item,
    output logic  o_pop_valid,
    input  logic  i_pop_ready
);

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QCW-1:0] r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_push_ready = (r_cnt != QCW'(QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign do_push      = i_push_valid && o_push_ready;
    assign do_pop       = o_pop_valid && i_pop_ready;
    assign o_item       = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QAW'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QAW'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ hw/rtl/cpu8_back.sv @@
// back: serializes one code point into its utf-8 bytes
module cpu8_back import cpu8_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_item      i_item,
    input  logic       i_pop_valid,
    output logic       o_pop_ready,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last,
    output logic       o_substituted
);

    logic [CP_W-1:0] r_cp;
    logic            r_sub;
    logic            r_busy;
    logic [1:0]      r_len;
    logic [1:0]      r_pos;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       r_out_sub;

    logic       out_adv;
    logic       emit;
    logic       fin;
    logic       pop;
    logic [1:0] new_len;
    logic [1:0] shift_sel;
    logic [7:0] cur_byte;

    // byte count minus one of the incoming code point
    always_comb begin
        priority if (i_item.cp < 21'h80) begin
            new_len = 2'd0;
        end else if (i_item.cp < 21'h800) begin
            new_len = 2'd1;
        end else if (i_item.cp < 21'h10000) begin
            new_len = 2'd2;
        end else begin
            new_len = 2'd3;
        end
    end

    // byte at the current position
    assign shift_sel = r_len - r_pos;
    always_comb begin
        if (r_pos == 2'd0) begin
            unique case (r_len)
                2'd0: cur_byte = {1'b0, r_cp[6:0]};
                2'd1: cur_byte = {3'b110, r_cp[10:6]};
                2'd2: cur_byte = {4'b1110, r_cp[15:12]};
                2'd3: cur_byte = {5'b11110, r_cp[20:18]};
            endcase
        end else begin
            unique case (shift_sel)
                2'd0:    cur_byte = {2'b10, r_cp[5:0]};
                2'd1:    cur_byte = {2'b10, r_cp[11:6]};
                default: cur_byte = {2'b10, r_cp[17:12]};
            endcase
        end
    end

    // handshakes
    assign out_adv     = !r_out_valid || !i_stall;
    assign emit        = r_busy && out_adv;
    assign fin         = emit && (r_pos == r_len);
    assign o_pop_ready = !r_busy || fin;
    assign pop         = i_pop_valid && o_pop_ready;

    // current item control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= 2'd0;
        end else if (pop) begin
            r_busy <= 1'b1;
            r_pos  <= 2'd0;
        end else if (fin) begin
            r_busy <= 1'b0;
        end else if (emit) begin
            r_pos <= r_pos + 1'b1;
        end
    end

    // current item payload
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cp  <= i_item.cp;
            r_sub <= i_item.sub;
            r_len <= new_len;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= cur_byte;
            r_out_last <= (r_pos == r_len);
            r_out_sub  <= r_sub;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last        = r_out_last;
    assign o_substituted = r_out_sub;

endmodule

@@ hw/rtl/codepage_to_utf8_encoder.sv @@
// top level of the code page to utf-8 encoder
//
//   channel   valid     stall     payload
//   input     i_valid   o_stall   i_op, i_data_byte, i_entry_index, i_entry_code_point
//   output    o_valid   i_stall   o_out_byte, o_last, o_substituted
//   config    i_cfg_we  -         i_cfg_wdata
//
// one input transaction per cycle while o_stall is low; an item passes the table read and
// stage one, the queue and the serializer load before o_valid rises, and the output register
// holds the byte. an item emits 1 to 4 output transactions at one per cycle while i_stall is
// low; the input stalls once the two-entry queue fills and stage one holds an item. reset is
// synchronous and clears control only; the code table is not cleared. either side may stall at any time.
module codepage_to_utf8_encoder import cpu8_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_op,
    input  logic [7:0]          i_data_byte,
    input  logic [TABLE_AW-1:0] i_entry_index,
    input  logic [ENTRY_W-1:0]  i_entry_code_point,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [7:0]          o_out_byte,
    output logic                o_last,
    output logic                o_substituted,
    input  logic                i_cfg_we,
    input  logic [CP_W-1:0]     i_cfg_wdata
);

    logic [CP_W-1:0] r_err_cp;
    t_item           front_item;
    t_item           q_item;
    logic            push_valid;
    logic            push_ready;
    logic            q_pop_valid;
    logic            q_pop_ready;

    // error code point register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_cp <= ERR_CP_RESET;
        end else if (i_cfg_we) begin
            r_err_cp <= i_cfg_wdata;
        end
    end

    cpu8_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_op               (i_op),
        .i_data_byte        (i_data_byte),
        .i_entry_index      (i_entry_index),
        .i_entry_code_point (i_entry_code_point),
        .i_err_cp           (r_err_cp),
        .o_item             (front_item),
        .o_push_valid       (push_valid),
        .i_push_ready       (push_ready)
    );

    cpu8_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (front_item),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .o_item       (q_item),
        .o_pop_valid  (q_pop_valid),
        .i_pop_ready  (q_pop_ready)
    );

    cpu8_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (q_item),
        .i_pop_valid   (q_pop_valid),
        .o_pop_ready   (q_pop_ready),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_last        (o_last),
        .o_substituted (o_substituted)
    );

endmodule

@@ test/codepage_to_utf8_encoder_tb.sv @@
// testbench of the code page to utf-8 encoder: random and directed byte streams, scoreboard check
`timescale 1ns / 100ps

module codepage_to_utf8_encoder_tb import cpu8_pkg::*;;

    localparam int DRAIN_CYCLES  = 8;
    localparam int IDLE_LIMIT    = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 70;
    localparam int NUM_PHASES    = 6;
    localparam int MAX_REPORTS   = 10;

    // code points at the encoding length boundaries, plus invalid ones
    localparam logic [ENTRY_W-1:0] BOUNDARY_CPS [11] = '{
        32'h0000_0000, 32'h0000_007F, 32'h0000_0080, 32'h0000_07FF,
        32'h0000_0800, 32'h0000_D800, 32'h0000_FFFF, 32'h0001_0000,
        32'h0010_FFFF, 32'h0011_0000, 32'hFFFF_FFFF
    };

    // one utf-8 output byte as it leaves the block
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       sub;
    } t_utf8_byte;

    // expected utf-8 byte stream, built from a private copy of table and register
    class utf8_scoreboard;
        logic [ENTRY_W-1:0] code_map [TABLE_DEPTH];
        logic [CP_W-1:0]    err_cp;
        t_utf8_byte         expected_q [$];
        int                 mismatches;

        function new();
            err_cp     = ERR_CP_RESET;
            mismatches = 0;
            foreach (code_map[i]) code_map[i] = '0;
        endfunction

        function void set_err_cp(input logic [CP_W-1:0] value);
            err_cp = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // split a code point into its utf-8 bytes
        function void push_encoding(input logic [ENTRY_W-1:0] cp, input logic sub);
            logic [7:0] seq [4];
            int         n;
            if (cp < 32'h80) begin
                seq[0] = cp[7:0];
                n = 1;
            end else if (cp < 32'h800) begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
                n = 2;
            end else if (cp < 32'h1_0000) begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
                n = 3;
            end else begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
                n = 4;
            end
            for (int k = 0; k < n; k++)
                expected_q.push_back('{data: seq[k], last: (k == n - 1), sub: sub});
        endfunction

        // accepted input transaction
        function void note_item(input logic op, input logic [7:0] data_byte,
                                input logic [TABLE_AW-1:0] idx,
                                input logic [ENTRY_W-1:0] cp);
            logic [ENTRY_W-1:0] entry;
            if (op == OP_LOAD) begin
                code_map[idx] = cp;
            end else if (data_byte == 8'h00) begin
                // end of string, nothing emitted
            end else if (data_byte < HIGH_BASE) begin
                expected_q.push_back('{data: data_byte, last: 1'b1, sub: 1'b0});
            end else begin
                entry = code_map[data_byte[6:0]];
                if (entry > MAX_CP)
                    push_encoding({{(ENTRY_W - CP_W){1'b0}}, err_cp}, 1'b1);
                else
                    push_encoding(entry, 1'b0);
            end
        endfunction

        // accepted output transaction against the oldest expected byte
        function void check_byte(input logic [7:0] data, input logic last, input logic sub);
            t_utf8_byte want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected output: byte %02h last %b sub %b", data, last, sub);
                return;
            end
            want = expected_q.pop_front();
            if (want.data !== data || want.last !== last || want.sub !== sub) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: expected byte %02h last %b sub %b, got %02h %b %b",
                             want.data, want.last, want.sub, data, last, sub);
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic                i_op = OP_CONVERT;
    logic [7:0]          i_data_byte = '0;
    logic [TABLE_AW-1:0] i_entry_index = '0;
    logic [ENTRY_W-1:0]  i_entry_code_point = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [7:0]          o_out_byte;
    logic                o_last;
    logic                o_substituted;
    logic                i_cfg_we = 1'b0;
    logic [CP_W-1:0]     i_cfg_wdata = '0;

    utf8_scoreboard sb;
    int             tx_idle_pct = 0;
    int             rx_stall_pct = 0;
    bit             hold_start = 1'b0;
    int             idle_cycles = 0;
    bit             slot_written [TABLE_DEPTH];
    int             written_q [$];

    codepage_to_utf8_encoder uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_op               (i_op),
        .i_data_byte        (i_data_byte),
        .i_entry_index      (i_entry_index),
        .i_entry_code_point (i_entry_code_point),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_out_byte         (o_out_byte),
        .o_last             (o_last),
        .o_substituted      (o_substituted),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // offer one input transaction and wait for it to be taken
    task automatic send_item(input logic op, input logic [7:0] data_byte,
                             input logic [TABLE_AW-1:0] idx, input logic [ENTRY_W-1:0] cp);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_valid            <= 1'b1;
        i_op               <= op;
        i_data_byte        <= data_byte;
        i_entry_index      <= idx;
        i_entry_code_point <= cp;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.note_item(op, data_byte, idx, cp);
    endtask

    // table write; remembers the slot so only written slots are ever read
    task automatic load_entry(input logic [TABLE_AW-1:0] idx, input logic [ENTRY_W-1:0] cp);
        send_item(OP_LOAD, 8'($urandom), idx, cp);
        if (!slot_written[idx]) begin
            slot_written[idx] = 1'b1;
            written_q.push_back(idx);
        end
    endtask

    function automatic logic [ENTRY_W-1:0] random_code_point();
        unique case ($urandom_range(6))
            0: return $urandom_range(32'h7F);
            1: return $urandom_range(32'h7FF, 32'h80);
            2: return $urandom_range(32'hFFFF, 32'h800);
            3: return $urandom_range(32'h10_FFFF, 32'h1_0000);
            4: return $urandom_range(32'hFFFF_FFFF, 32'h11_0000);
            5: return BOUNDARY_CPS[$urandom_range(10)];
            default: return $urandom;
        endcase
    endfunction

    // mostly string bytes over written slots, some table loads and string ends
    task automatic send_random_item();
        int         pick;
        logic [7:0] data_byte;
        pick = $urandom_range(99);
        if (pick < 15) begin
            load_entry(TABLE_AW'($urandom), random_code_point());
        end else begin
            pick = $urandom_range(99);
            if (pick < 8)
                data_byte = 8'h00;
            else if (pick < 35 || written_q.size() == 0)
                data_byte = 8'($urandom_range(127, 1));
            else
                data_byte = HIGH_BASE | 8'(written_q[$urandom_range(written_q.size() - 1)]);
            send_item(OP_CONVERT, data_byte, TABLE_AW'($urandom), $urandom);
        end
    endtask

    // stop offering, let every expected byte out, then let the pipeline settle
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_err_cp(input logic [CP_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_err_cp(value);
    endtask

    // output side: check accepted transactions, stall at random or hold off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0)
                sb.check_byte(o_out_byte, o_last, o_substituted);
            if (hold_start) begin
                hold_start = 1'b0;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid === 1'b1 && o_stall === 1'b0) || (o_valid === 1'b1 && i_stall === 1'b0))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // stimulus
    initial begin
        logic [CP_W-1:0] phase_cfg [NUM_PHASES];
        int              tx_mode [4];
        int              rx_mode [4];
        sb = new();
        phase_cfg = '{21'h1F_FFFF, 21'h0, 21'h10_FFFF, 21'h7FF,
                      CP_W'($urandom_range(21'h1F_FFFF)), ERR_CP_RESET};
        tx_mode = '{0, 73, 0, 24};
        rx_mode = '{0, 0, 73, 24};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: boundary code points, invalid entries, top slot, ascii ends, string end
        for (int i = 0; i < 11; i++)
            load_entry(TABLE_AW'(i), BOUNDARY_CPS[i]);
        load_entry(TABLE_AW'(TABLE_DEPTH - 1), 32'h0000_20AC);
        for (int i = 0; i < 11; i++)
            send_item(OP_CONVERT, HIGH_BASE + 8'(i), TABLE_AW'($urandom), $urandom);
        send_item(OP_CONVERT, 8'hFF, '1, '1);
        send_item(OP_CONVERT, 8'h7F, '0, '0);
        send_item(OP_CONVERT, 8'h00, TABLE_AW'($urandom), $urandom);

        // random phases, each with its own error code point and one of four idling mixes
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_pipeline();
            write_err_cp(phase_cfg[p]);
            tx_idle_pct  = tx_mode[p % 4];
            rx_stall_pct = rx_mode[p % 4];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 0 && n == 10)
                    hold_start = 1'b1;
                send_random_item();
            end
        end

        drain_pipeline();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
